// ----- src/dbsd_pkg.sv -----
// Shared types and constants for the delta / bitmask sparse block decoder.
package dbsd_pkg;

    // Widths fixed by the token and result formats.
    localparam int TOKEN_W       = 32;
    localparam int POS_W         = 4;
    localparam int MASK_W        = 16;

    // Default configuration.
    localparam int BLOCK_LEN_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;

    // Header token value that selects sparse mode.
    localparam logic signed [TOKEN_W-1:0] SPARSE_HEADER = 32'sd1;

    // Commands passed from the front end to the back end.
    typedef enum logic [2:0] {
        CMD_HEADER,
        CMD_BASE,
        CMD_MASK,
        CMD_SPARSE,
        CMD_DELTA
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                  kind;
        logic signed [TOKEN_W-1:0]  data;
    } t_cmd;

endpackage

// ----- src/block_delta_sparse_decoder_top.sv -----
// Top level of the delta / bitmask sparse block decoder.
// Tokens are taken one per cycle while the four-entry command queue has room. The back end takes
// a new command only when it is through with the last one: a header or base token only updates
// its state, a mask token that opens a run of cleared positions emits one base sample for each
// of them, and a value token is taken and then emits its sample, followed in sparse mode by the
// run of cleared positions that it leads. All samples leave through the single output register,
// and output stalls hold the back end. A sample passes the command queue, the back end's command
// registers and then the output register. In sparse mode the mask bits are read with the first
// sample in the most significant used bit, and when the block is longer than sixteen the
// positions past the mask each take a value token. Sums are saturated to the signed 32-bit
// range.
module block_delta_sparse_decoder_top #(
    parameter int BLOCK_LEN = dbsd_pkg::BLOCK_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [dbsd_pkg::TOKEN_W-1:0] i_token,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [dbsd_pkg::TOKEN_W-1:0] o_sample,
    output logic [dbsd_pkg::POS_W-1:0]          o_position,
    output logic                                o_last_of_run,
    output logic                                o_end_of_block
);
    import dbsd_pkg::*;

    logic  queue_full;
    logic  push;
    t_cmd  front_cmd;
    logic  cmd_valid;
    t_cmd  head_cmd;
    logic  pop;

    // Token classification.
    dbsd_front #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_token      (i_token),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    // Command queue between the two halves.
    dbsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    // Sample generation.
    dbsd_back #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample       (o_sample),
        .o_position     (o_position),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_block (o_end_of_block)
    );

endmodule

// ----- src/dbsd_front.sv -----
// Front end: accepts tokens, tracks the block phase and classifies each token as a command.
module dbsd_front #(
    parameter int BLOCK_LEN = dbsd_pkg::BLOCK_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [dbsd_pkg::TOKEN_W-1:0] i_token,
    input  logic                               i_queue_full,
    output logic                               o_push,
    output dbsd_pkg::t_cmd                     o_cmd
);
    import dbsd_pkg::*;

    localparam int EFF      = (BLOCK_LEN < MASK_W) ? BLOCK_LEN : MASK_W;
    localparam int EXTRA    = (BLOCK_LEN > MASK_W) ? BLOCK_LEN - MASK_W : 0;
    localparam int CW       = $clog2(BLOCK_LEN + 1);
    localparam logic [MASK_W-1:0] LOW_MASK = MASK_W'((17'(1) << EFF) - 17'(1));

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BASE,
        PH_MASK,
        PH_VALUES
    } t_phase;

    t_phase          r_phase;
    logic            r_sparse;
    logic [CW-1:0]   r_left;

    logic            accept;
    logic [MASK_W-1:0] mask_eff;
    logic [2:0]      nib_cnt [4];
    logic [4:0]      pop_cnt;
    logic [CW-1:0]   set_cnt;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    // Number of value tokens a sparse block still needs once its mask is known.
    always_comb begin
        mask_eff = i_token[MASK_W-1:0] & LOW_MASK;
        for (int i = 0; i < 4; i++) begin
            nib_cnt[i] = 3'(mask_eff[4*i]) + 3'(mask_eff[4*i+1])
                       + 3'(mask_eff[4*i+2]) + 3'(mask_eff[4*i+3]);
        end
        pop_cnt = 5'(nib_cnt[0]) + 5'(nib_cnt[1]) + 5'(nib_cnt[2]) + 5'(nib_cnt[3]);
        set_cnt = CW'(pop_cnt) + CW'(EXTRA);
    end

    // Command classification follows the current phase.
    always_comb begin
        o_cmd.data = i_token;
        unique case (r_phase)
            PH_HEADER: o_cmd.kind = CMD_HEADER;
            PH_BASE:   o_cmd.kind = CMD_BASE;
            PH_MASK:   o_cmd.kind = CMD_MASK;
            PH_VALUES: o_cmd.kind = r_sparse ? CMD_SPARSE : CMD_DELTA;
            default:   o_cmd.kind = CMD_HEADER;
        endcase
    end

    // Phase sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_sparse <= 1'b0;
            r_left   <= '0;
        end else if (accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (i_token == SPARSE_HEADER) begin
                        r_sparse <= 1'b1;
                        r_phase  <= PH_BASE;
                    end else begin
                        r_sparse <= 1'b0;
                        r_left   <= CW'(BLOCK_LEN);
                        r_phase  <= PH_VALUES;
                    end
                end
                PH_BASE: begin
                    r_phase <= PH_MASK;
                end
                PH_MASK: begin
                    r_left  <= set_cnt;
                    r_phase <= (set_cnt == '0) ? PH_HEADER : PH_VALUES;
                end
                PH_VALUES: begin
                    r_left <= r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        r_phase <= PH_HEADER;
                    end
                end
                default: r_phase <= PH_HEADER;
            endcase
        end
    end

endmodule

// ----- src/dbsd_queue.sv -----
// Short command queue that decouples the front end from the back end.
module dbsd_queue #(
    parameter int DEPTH = dbsd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dbsd_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output dbsd_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import dbsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_cmd            r_store [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_count;

    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_store[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/dbsd_back.sv -----
// Back end: carries out commands and emits samples through a registered output stage.
module dbsd_back #(
    parameter int BLOCK_LEN = dbsd_pkg::BLOCK_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    input  dbsd_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [dbsd_pkg::TOKEN_W-1:0] o_sample,
    output logic [dbsd_pkg::POS_W-1:0]          o_position,
    output logic                                o_last_of_run,
    output logic                                o_end_of_block
);
    import dbsd_pkg::*;

    localparam int EFF = (BLOCK_LEN < MASK_W) ? BLOCK_LEN : MASK_W;
    localparam int PW  = $clog2(BLOCK_LEN + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VALUE,
        ST_CLEAR
    } t_state;

    t_state                     r_state;
    logic [PW-1:0]              r_pos;
    logic [MASK_W-1:0]          r_mask;
    logic signed [TOKEN_W-1:0]  r_base;
    logic signed [TOKEN_W-1:0]  r_sum;
    logic signed [TOKEN_W-1:0]  r_val;
    logic                       r_sparse;

    logic                       slot_free;
    logic                       sample_load;
    logic [PW-1:0]              pos_next;
    logic                       last_next;
    logic signed [TOKEN_W-1:0]  sum_sparse;
    logic signed [TOKEN_W-1:0]  sum_delta;

    // A position is set by its mask bit, counted from the top; positions past the mask are set.
    function automatic logic is_set(input logic [MASK_W-1:0] m, input logic [PW-1:0] p);
        logic [3:0] idx;
        idx = 4'(EFF - 1) - 4'(p);
        return (p >= PW'(EFF)) || m[idx];
    endfunction

    // Signed add clamped to the 32-bit range.
    function automatic logic signed [TOKEN_W-1:0] sat_add(
        input logic signed [TOKEN_W-1:0] a,
        input logic signed [TOKEN_W-1:0] b
    );
        logic signed [TOKEN_W:0] s;
        s = {a[TOKEN_W-1], a} + {b[TOKEN_W-1], b};
        if (s[TOKEN_W] != s[TOKEN_W-1]) begin
            return s[TOKEN_W] ? {1'b1, {(TOKEN_W-1){1'b0}}} : {1'b0, {(TOKEN_W-1){1'b1}}};
        end
        return s[TOKEN_W-1:0];
    endfunction

    assign slot_free   = !o_valid || i_ready;
    assign sample_load = (r_state != ST_IDLE) && slot_free;
    assign pos_next    = r_pos + PW'(1);
    assign last_next   = (pos_next >= PW'(BLOCK_LEN)) || is_set(r_mask, pos_next);
    assign sum_sparse  = sat_add(r_val, r_base);
    assign sum_delta   = sat_add(r_sum, r_val);
    assign o_pop       = (r_state == ST_IDLE) && i_cmd_valid;

    // Command sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
            r_pos   <= '0;
            r_mask  <= '0;
            r_base  <= '0;
            r_sum   <= '0;
        end else begin
            if (sample_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (i_cmd.kind)
                            CMD_HEADER: begin
                                r_pos <= '0;
                                r_sum <= '0;
                            end
                            CMD_BASE: begin
                                r_base <= i_cmd.data;
                            end
                            CMD_MASK: begin
                                r_mask <= i_cmd.data[MASK_W-1:0];
                                r_pos  <= '0;
                                if (!is_set(i_cmd.data[MASK_W-1:0], '0)) begin
                                    r_state <= ST_CLEAR;
                                end
                            end
                            CMD_SPARSE, CMD_DELTA: begin
                                r_val    <= i_cmd.data;
                                r_sparse <= (i_cmd.kind == CMD_SPARSE);
                                r_state  <= ST_VALUE;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_VALUE: begin
                    if (slot_free) begin
                        o_position     <= POS_W'(r_pos);
                        o_end_of_block <= (r_pos == PW'(BLOCK_LEN - 1));
                        r_pos          <= pos_next;
                        if (r_sparse) begin
                            o_sample      <= sum_sparse;
                            o_last_of_run <= last_next;
                            r_state       <= last_next ? ST_IDLE : ST_CLEAR;
                        end else begin
                            o_sample      <= sum_delta;
                            r_sum         <= sum_delta;
                            o_last_of_run <= 1'b1;
                            r_state       <= ST_IDLE;
                        end
                    end
                end
                ST_CLEAR: begin
                    if (slot_free) begin
                        o_sample       <= r_base;
                        o_position     <= POS_W'(r_pos);
                        o_end_of_block <= (r_pos == PW'(BLOCK_LEN - 1));
                        o_last_of_run  <= last_next;
                        r_pos          <= pos_next;
                        if (last_next) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- src/dbsd_checker.sv -----
// Port-level checks for the decoder top level, bound to every instance.
module dbsd_checker #(
    parameter int BLOCK_LEN = dbsd_pkg::BLOCK_LEN_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [dbsd_pkg::TOKEN_W-1:0] o_sample,
    input logic [dbsd_pkg::POS_W-1:0]          o_position,
    input logic                                o_last_of_run,
    input logic                                o_end_of_block
);
    import dbsd_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_LEN - 1);

    // A stalled item holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample) && $stable(o_position)
            && $stable(o_last_of_run) && $stable(o_end_of_block))
        else $error("output item changed while stalled");

    // The final sample of a block always closes the run of its token.
    a_eob_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_block |-> o_last_of_run)
        else $error("end of block without end of run");

    // End of block is flagged at the last position only.
    a_eob_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_block |-> o_position == LAST_POS)
        else $error("end of block at wrong position");

    // No item is offered straight after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind block_delta_sparse_decoder_top dbsd_checker #(
    .BLOCK_LEN (BLOCK_LEN)
) u_dbsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_sample       (o_sample),
    .o_position     (o_position),
    .o_last_of_run  (o_last_of_run),
    .o_end_of_block (o_end_of_block)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the delta / bitmask sparse block decoder.
`timescale 1ns / 1ps

module tb;

    import dbsd_pkg::*;

    localparam int BLK           = BLOCK_LEN_DEF;
    localparam int TOTAL_ITEMS   = 460;
    localparam int LONG_HOLD     = 200;
    localparam int DRAIN_CYCLES  = 16;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DIRECTED_ROWS = 25;

    localparam logic signed [TOKEN_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TOKEN_W-1:0] SUM_MIN = 32'sh8000_0000;

    // One decoded sample as it leaves the block.
    typedef struct packed {
        logic signed [TOKEN_W-1:0] value;
        logic [POS_W-1:0]          pos;
        logic                      run_last;
        logic                      block_end;
    } t_decoded;

    // One row of the directed table; the typed sample is checked only where typed is set.
    typedef struct packed {
        logic signed [TOKEN_W-1:0] token;
        logic                      typed;
        t_decoded                  want;
    } t_stim_row;

    typedef enum logic [1:0] {
        WANT_HEADER,
        WANT_BASE,
        WANT_MASK,
        WANT_VALUES
    } t_stream_phase;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_CADENCE
    } t_rx_style;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic signed [TOKEN_W-1:0] i_token = '0;
    logic                      i_ready = 1'b0;
    logic                      o_ready;
    logic                      o_valid;
    logic signed [TOKEN_W-1:0] o_sample;
    logic [POS_W-1:0]          o_position;
    logic                      o_last_of_run;
    logic                      o_end_of_block;

    // Decoder state mirrored by the predictor.
    t_stream_phase             dec_phase  = WANT_HEADER;
    logic                      dec_sparse = 1'b0;
    int unsigned               dec_pos    = 0;
    logic [MASK_W-1:0]         dec_mask   = '0;
    logic signed [TOKEN_W-1:0] dec_base   = '0;
    logic signed [TOKEN_W-1:0] dec_sum    = '0;

    t_decoded    pending_samples[$];
    t_stim_row   directed_rows[DIRECTED_ROWS];
    int unsigned tokens_taken  = 0;
    int unsigned mismatches    = 0;
    int unsigned hold_requests = 0;
    int unsigned quiet_cycles  = 0;

    block_delta_sparse_decoder_top #(.BLOCK_LEN(BLK)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_token       (i_token),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample      (o_sample),
        .o_position    (o_position),
        .o_last_of_run (o_last_of_run),
        .o_end_of_block(o_end_of_block)
    );

    // Clock and a single reset at the start of the run.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Signed addition clamped to the 32-bit range.
    function automatic logic signed [TOKEN_W-1:0] sat_sum(input logic signed [TOKEN_W-1:0] a,
                                                          input logic signed [TOKEN_W-1:0] b);
        logic signed [TOKEN_W:0] s;
        s = {a[TOKEN_W-1], a} + {b[TOKEN_W-1], b};
        if (s[TOKEN_W] != s[TOKEN_W-1]) begin
            return s[TOKEN_W] ? SUM_MIN : SUM_MAX;
        end
        return s[TOKEN_W-1:0];
    endfunction

    // The first sample of a block sits on the most significant used mask bit.
    function automatic logic position_is_set(input int unsigned p);
        int unsigned eff;
        eff = (BLK < MASK_W) ? BLK : MASK_W;
        if (p >= eff) begin
            return 1'b1;
        end
        return dec_mask[eff - 1 - p];
    endfunction

    function automatic void emit_sample(ref t_decoded res[$], input logic signed [TOKEN_W-1:0] v,
                                        input int unsigned p);
        t_decoded d;
        d.value     = v;
        d.pos       = p[POS_W-1:0];
        d.run_last  = 1'b0;
        d.block_end = (p == BLK - 1);
        res.push_back(d);
    endfunction

    // Cleared positions carry the base alone and are emitted as soon as they are known.
    function automatic void emit_cleared_run(ref t_decoded res[$]);
        while (dec_pos < BLK && !position_is_set(dec_pos)) begin
            emit_sample(res, dec_base, dec_pos);
            dec_pos++;
        end
        if (dec_pos >= BLK) begin
            dec_phase = WANT_HEADER;
        end
    endfunction

    // Advances the mirrored state by one token and returns the samples it causes.
    function automatic void decode_token(input logic signed [TOKEN_W-1:0] tok,
                                         ref t_decoded res[$]);
        t_decoded tail;
        res.delete();
        case (dec_phase)
            WANT_HEADER: begin
                dec_pos = 0;
                dec_sum = '0;
                dec_sparse = (tok == SPARSE_HEADER);
                dec_phase = dec_sparse ? WANT_BASE : WANT_VALUES;
            end
            WANT_BASE: begin
                dec_base = tok;
                dec_phase = WANT_MASK;
            end
            WANT_MASK: begin
                dec_mask = tok[MASK_W-1:0];
                dec_pos = 0;
                dec_phase = WANT_VALUES;
                emit_cleared_run(res);
            end
            default: begin
                if (dec_sparse) begin
                    emit_sample(res, sat_sum(tok, dec_base), dec_pos);
                    dec_pos++;
                    emit_cleared_run(res);
                end else begin
                    dec_sum = sat_sum(dec_sum, tok);
                    emit_sample(res, dec_sum, dec_pos);
                    dec_pos++;
                    if (dec_pos >= BLK) begin
                        dec_phase = WANT_HEADER;
                    end
                end
            end
        endcase
        if (res.size() > 0) begin
            tail = res.pop_back();
            tail.run_last = 1'b1;
            res.push_back(tail);
        end
    endfunction

    // Values lean towards the saturation limits and small magnitudes.
    function automatic logic signed [TOKEN_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            return $urandom;
        end
        if (pick < 40) begin
            case ($urandom_range(0, 3))
                0:       return SUM_MAX;
                1:       return SUM_MIN;
                2:       return SUM_MAX - $urandom_range(0, 1000);
                default: return SUM_MIN + $urandom_range(0, 1000);
            endcase
        end
        return int'($urandom_range(0, 200000)) - 100000;
    endfunction

    // Picks a token that fits what the decoder expects next, with random content.
    function automatic logic signed [TOKEN_W-1:0] next_token();
        int unsigned pick;
        logic [MASK_W-1:0] m;
        pick = $urandom_range(0, 99);
        case (dec_phase)
            WANT_HEADER: begin
                if (pick < 55) return SPARSE_HEADER;
                if (pick < 70) return '0;
                return $urandom;
            end
            WANT_MASK: begin
                if (pick < 10)      m = '0;
                else if (pick < 20) m = '1;
                else if (pick < 60) m = MASK_W'($urandom);
                else if (pick < 80) m = MASK_W'($urandom & $urandom & $urandom);
                else                m = MASK_W'($urandom | $urandom);
                return {16'($urandom_range(0, 16'hFFFF)), m};
            end
            default: return random_value();
        endcase
    endfunction

    // Offers one token, waits for it to be taken and records what it should produce.
    task automatic push_token(input logic signed [TOKEN_W-1:0] tok, input logic typed,
                              input t_decoded want);
        t_decoded got[$];
        i_valid <= 1'b1;
        i_token <= tok;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tokens_taken++;
        decode_token(tok, got);
        if (typed) begin
            if (got.size() != 1 || got[0] != want) begin
                mismatches++;
                $display("%0t: table row disagrees with prediction: expected %p actual %p",
                         $time, want, got);
            end
            pending_samples.push_back(want);
        end else begin
            foreach (got[k]) pending_samples.push_back(got[k]);
        end
    endtask

    task automatic idle_for(input int unsigned cycles);
        if (cycles != 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stops offering tokens until every predicted sample has come out.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Token source: directed table first, then random bursts.
    initial begin : token_source
        int unsigned burst_left;
        bit held;
        bit paused_late;
        burst_left = 0;
        held = 1'b0;
        paused_late = 1'b0;
        directed_rows = '{
            '{SUM_MIN,               1'b0, '0},
            '{SUM_MAX,               1'b1, '{SUM_MAX, 4'd0, 1'b1, 1'b0}},
            '{32'sd1,                1'b1, '{SUM_MAX, 4'd1, 1'b1, 1'b0}},
            '{SUM_MIN,               1'b1, '{-32'sd1, 4'd2, 1'b1, 1'b0}},
            '{SUM_MIN,               1'b1, '{SUM_MIN, 4'd3, 1'b1, 1'b0}},
            '{-32'sd1,               1'b1, '{SUM_MIN, 4'd4, 1'b1, 1'b0}},
            '{SUM_MAX,               1'b0, '0},
            '{32'sd0,                1'b0, '0},
            '{32'sd1000,             1'b0, '0},
            '{-32'sd1000,            1'b0, '0},
            '{32'sd123456,           1'b0, '0},
            '{-32'sd7,               1'b0, '0},
            '{32'sd2,                1'b0, '0},
            '{32'sd999,              1'b0, '0},
            '{-32'sd2147483647,      1'b0, '0},
            '{32'sd65535,            1'b0, '0},
            '{-32'sd42,              1'b0, '0},
            '{SPARSE_HEADER,         1'b0, '0},
            '{SUM_MIN,               1'b0, '0},
            '{32'shFFFF_0000,        1'b0, '0},
            '{SPARSE_HEADER,         1'b0, '0},
            '{SUM_MAX,               1'b0, '0},
            '{32'sh0000_8001,        1'b0, '0},
            '{32'sd1,                1'b0, '0},
            '{-32'sd5,               1'b1, '{32'sd2147483642, 4'd15, 1'b1, 1'b1}}
        };

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // Directed part: extremes, saturation, both modes and an all-cleared mask.
        foreach (directed_rows[r]) begin
            if ($urandom_range(0, 2) == 0) begin
                idle_for($urandom_range(1, 3));
            end
            push_token(directed_rows[r].token, directed_rows[r].typed, directed_rows[r].want);
        end
        wait_for_drain();

        // Random part in bursts; one long receiver hold-off and one full drain on the way.
        while (tokens_taken < TOTAL_ITEMS) begin
            if (tokens_taken >= 330 && !paused_late) begin
                paused_late = 1'b1;
                wait_for_drain();
            end
            if (burst_left == 0) begin
                if (tokens_taken >= 200 && !held) begin
                    held = 1'b1;
                    hold_requests++;
                    burst_left = 48;
                end else if ($urandom_range(0, 9) == 0) begin
                    burst_left = 64;
                end else begin
                    idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                    burst_left = $urandom_range(1, 16);
                end
            end
            burst_left--;
            push_token(next_token(), 1'b0, '0);
        end
        wait_for_drain();

        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Sample sink: changes its stall style after each segment of random length and holds off on request.
    initial begin : result_sink
        int unsigned seg_left;
        int unsigned holds_done;
        int unsigned tick;
        t_rx_style style;
        seg_left = 0;
        holds_done = 0;
        tick = 0;
        style = RX_OPEN;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 64);
                    style = t_rx_style'($urandom_range(0, 3));
                end
                seg_left--;
                case (style)
                    RX_OPEN:  i_ready <= 1'b1;
                    RX_LIGHT: i_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: i_ready <= ($urandom_range(0, 9) < 3);
                    default:  i_ready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // Each sample taken is compared with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_decoded want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_samples.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected sample: expected none actual value %0d position %0d",
                         $time, o_sample, o_position);
            end else begin
                want = pending_samples.pop_front();
                if (o_sample !== want.value) begin
                    mismatches++;
                    $display("%0t: sample mismatch: expected %0d actual %0d",
                             $time, want.value, o_sample);
                end
                if (o_position !== want.pos) begin
                    mismatches++;
                    $display("%0t: position mismatch: expected %0d actual %0d",
                             $time, want.pos, o_position);
                end
                if (o_last_of_run !== want.run_last) begin
                    mismatches++;
                    $display("%0t: last_of_run mismatch: expected %0b actual %0b",
                             $time, want.run_last, o_last_of_run);
                end
                if (o_end_of_block !== want.block_end) begin
                    mismatches++;
                    $display("%0t: end_of_block mismatch: expected %0b actual %0b",
                             $time, want.block_end, o_end_of_block);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

// ----- filelist.f -----
src/dbsd_pkg.sv
src/dbsd_front.sv
src/dbsd_queue.sv
src/dbsd_back.sv
src/block_delta_sparse_decoder_top.sv
src/dbsd_checker.sv
tb/tb.sv
